### design/eec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_pkg
// Shared widths, sequencer states and control structs for the extended
// Euclid coefficient unit.
// ----------------------------------------------------------------------------
package eec_pkg;

  // Working width of the coefficient arithmetic (8..64).
  localparam int DataWidth    = 64;
  // Remainders live in the operands' low DataWidth-1 bits.
  localparam int OperandWidth = DataWidth - 1;
  localparam int CountWidth   = $clog2(OperandWidth + 1);

  // Fixed port field widths.
  localparam int FieldWidth   = 63;
  localparam int CoefWidth    = 64;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TEST,
    ST_DIV,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage : eec_pkg
`default_nettype wire

### design/eec_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_in_if
// Operand channel: valid/ready handshake carrying both operands.
// ----------------------------------------------------------------------------
interface eec_in_if;
  logic                           valid;
  logic                           ready;
  logic [eec_pkg::FieldWidth-1:0] modulus_value;
  logic [eec_pkg::FieldWidth-1:0] operand_value;

  modport source (output valid, output modulus_value, output operand_value, input ready);
  modport sink   (input valid, input modulus_value, input operand_value, output ready);
endinterface : eec_in_if
`default_nettype wire

### design/eec_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_out_if
// Result channel: valid/ready handshake carrying the signed coefficient.
// ----------------------------------------------------------------------------
interface eec_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [eec_pkg::CoefWidth-1:0] coefficient;

  modport source (output valid, output coefficient, input ready);
  modport sink   (input valid, input coefficient, output ready);
endinterface : eec_out_if
`default_nettype wire

### design/eec_divmul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// eec_divmul
// Bit-serial restoring divider, one quotient bit per cycle, with the
// quotient folded MSB first into a running product mult*q mod 2^DataWidth.
// ----------------------------------------------------------------------------
module eec_divmul (
  input  wire                                   clk,
  input  wire                                   rst,
  input  eec_pkg::div_ctrl_t                    ctrl,
  input  wire  [eec_pkg::OperandWidth-1:0]      dividend,
  input  wire  [eec_pkg::OperandWidth-1:0]      divisor,
  input  wire  [eec_pkg::DataWidth-1:0]         mult,
  output eec_pkg::div_stat_t                    stat,
  output logic [eec_pkg::OperandWidth-1:0]      remainder,
  output logic [eec_pkg::DataWidth-1:0]         product
);

  logic [eec_pkg::OperandWidth-1:0] dvd;
  logic [eec_pkg::CountWidth-1:0]   cnt;
  logic                             busy;
  logic                             done;

  logic [eec_pkg::OperandWidth:0]   trial;
  logic [eec_pkg::OperandWidth:0]   diff;
  logic                             qbit;
  logic [eec_pkg::OperandWidth-1:0] remainder_next;
  logic [eec_pkg::DataWidth-1:0]    product_next;

  always_comb begin
    trial = {remainder, dvd[eec_pkg::OperandWidth-1]};
    diff  = trial - {1'b0, divisor};
    qbit  = (trial >= {1'b0, divisor});
    remainder_next = qbit ? diff[eec_pkg::OperandWidth-1:0]
                          : trial[eec_pkg::OperandWidth-1:0];
    // Horner step: product = 2*product + qbit*mult
    product_next = {product[eec_pkg::DataWidth-2:0], 1'b0}
                 + (qbit ? mult : '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy <= 1'b1;
        cnt  <= eec_pkg::CountWidth'(eec_pkg::OperandWidth);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == eec_pkg::CountWidth'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      remainder <= '0;
      dvd       <= dividend;
      product   <= '0;
    end else if (busy) begin
      remainder <= remainder_next;
      dvd       <= {dvd[eec_pkg::OperandWidth-2:0], 1'b0};
      product   <= product_next;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule : eec_divmul
`default_nettype wire

### design/extended_euclid_coefficient_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// extended_euclid_coefficient_unit
// Extended Euclid: returns the Bezout coefficient y of b in a*x + b*y = gcd.
// ----------------------------------------------------------------------------
//  channel   | dir | fields                         | handshake
//  ----------+-----+--------------------------------+------------
//  operands  | in  | modulus_value, operand_value   | valid/ready
//  result    | out | coefficient (signed)           | valid/ready
//
//  Each Euclid iteration is a zero test, a divide in the shared serial
//  divider at one quotient bit per cycle, and the update.
//  A transaction repeats the iteration until r1 is zero (k <= ~92 iterations).
//  operands.ready is high only while idle; one item is in flight at a time.
//  The result register holds until taken; a finished item waits for it.
//  rst is synchronous and clears the sequencer and the result valid.
// ----------------------------------------------------------------------------
module extended_euclid_coefficient_unit (
  input wire        clk,
  input wire        rst,
  eec_in_if.sink    operands,
  eec_out_if.source result
);

  eec_pkg::state_t    state;
  eec_pkg::state_t    state_next;
  eec_pkg::div_ctrl_t div_ctrl;
  eec_pkg::div_stat_t div_stat;

  logic [eec_pkg::OperandWidth-1:0] r0;
  logic [eec_pkg::OperandWidth-1:0] r1;
  logic [eec_pkg::DataWidth-1:0]    y0;
  logic [eec_pkg::DataWidth-1:0]    y1;
  logic signed [eec_pkg::CoefWidth-1:0] coefficient;
  logic                             out_valid;

  logic [eec_pkg::OperandWidth-1:0] rem;
  logic [eec_pkg::DataWidth-1:0]    prod;

  logic in_accept;
  logic load;
  logic update;
  logic emit;

  eec_divmul u_divmul (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .dividend  (r0),
    .divisor   (r1),
    .mult      (y1),
    .stat      (div_stat),
    .remainder (rem),
    .product   (prod)
  );

  assign operands.ready     = (state == eec_pkg::ST_IDLE);
  assign in_accept          = operands.valid && operands.ready;
  assign result.valid       = out_valid;
  assign result.coefficient = coefficient;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= eec_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next     = state;
    div_ctrl.start = 1'b0;
    load           = 1'b0;
    update         = 1'b0;
    emit           = 1'b0;
    unique case (state)
      eec_pkg::ST_IDLE: begin
        if (in_accept) begin
          load       = 1'b1;
          state_next = eec_pkg::ST_TEST;
        end
      end
      eec_pkg::ST_TEST: begin
        if (r1 == '0) begin
          state_next = eec_pkg::ST_FINISH;
        end else begin
          div_ctrl.start = 1'b1;
          state_next     = eec_pkg::ST_DIV;
        end
      end
      eec_pkg::ST_DIV: begin
        if (div_stat.done) begin
          update     = 1'b1;
          state_next = eec_pkg::ST_TEST;
        end
      end
      eec_pkg::ST_FINISH: begin
        if (!out_valid || result.ready) begin
          emit       = 1'b1;
          state_next = eec_pkg::ST_IDLE;
        end
      end
      default: state_next = eec_pkg::ST_IDLE;
    endcase
  end

  // older remainder r0 pairs with y0, newer r1 with y1
  always_ff @(posedge clk) begin
    if (load) begin
      r0 <= operands.operand_value[eec_pkg::OperandWidth-1:0];
      r1 <= operands.modulus_value[eec_pkg::OperandWidth-1:0];
      y0 <= eec_pkg::DataWidth'(1);
      y1 <= '0;
    end else if (update) begin
      r0 <= r1;
      r1 <= rem;
      y0 <= y1;
      y1 <= y0 - prod;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      coefficient <= eec_pkg::CoefWidth'($signed(y0));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  a_ready_div_idle: assert property (@(posedge clk) disable iff (rst)
    operands.ready |-> !div_stat.busy)
    else $error("accepting operands while the divider is busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> (state == eec_pkg::ST_DIV))
    else $error("divider finished outside the divide state");

  a_accept_to_test: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> (state == eec_pkg::ST_TEST))
    else $error("accepted transaction did not start the loop");

  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == eec_pkg::ST_DIV) |-> (r1 != '0))
    else $error("division by a zero remainder");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    emit |=> out_valid)
    else $error("finished result not presented");

endmodule : extended_euclid_coefficient_unit
`default_nettype wire
